// ===== design/bpsid_pkg.sv =====
// Shared types and status codes for the binary polynomial signed integer decoder.
package bpsid_pkg;

    localparam int CoeffWidth = 60;
    localparam int ValueWidth = 64;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [1:0] STATUS_RANGE    = 2'd3;

    localparam logic CFG_MODULUS       = 1'b0;
    localparam logic CFG_NARROW_RESULT = 1'b1;

    typedef struct packed {
        logic [CoeffWidth-1:0] coeff;
        logic                  first;
        logic                  last;
    } in_item_t;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value;
        logic [1:0]                   status;
    } out_item_t;

    typedef struct packed {
        logic                         first;
        logic                         last;
        logic                         invalid;
        logic signed [ValueWidth-1:0] addend;
    } work_item_t;

endpackage

// ===== design/bpsid_front.sv =====
// Front end: lifts each coefficient to a centered signed addend and flags invalid ones.
module bpsid_front
    import bpsid_pkg::*;
(
    input  logic [CoeffWidth-1:0] modulus,
    input  in_item_t              in_item,
    output work_item_t            work_item
);

    logic [CoeffWidth:0]   modulus_inc;
    logic [CoeffWidth-1:0] threshold;
    logic [CoeffWidth-1:0] magnitude;
    logic                  negative;

    always_comb begin
        modulus_inc = {1'b0, modulus} + {{CoeffWidth{1'b0}}, 1'b1};
        if (modulus == CoeffWidth'(2)) begin
            threshold = CoeffWidth'(2);
        end else begin
            threshold = modulus_inc[CoeffWidth:1];
        end
        negative  = in_item.coeff >= threshold;
        magnitude = modulus - in_item.coeff;
        work_item.first   = in_item.first;
        work_item.last    = in_item.last;
        work_item.invalid = in_item.coeff >= modulus;
        if (negative) begin
            work_item.addend = -$signed({{(ValueWidth-CoeffWidth){1'b0}}, magnitude});
        end else begin
            work_item.addend = $signed({{(ValueWidth-CoeffWidth){1'b0}}, in_item.coeff});
        end
    end

endmodule

// ===== design/bpsid_queue.sv =====
// Small register queue between the front end and the accumulator.
module bpsid_queue
    import bpsid_pkg::*;
#(
    parameter int Depth = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  work_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output work_item_t pop_item
);

    localparam int PtrWidth = $clog2(Depth);
    localparam int CntWidth = $clog2(Depth + 1);

    work_item_t                entries_reg [Depth];
    logic [PtrWidth-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0]       count_reg, count_next;

    assign full      = count_reg == CntWidth'(Depth);
    assign not_empty = count_reg != '0;
    assign pop_item  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/bpsid_back.sv =====
// Back end: doubles and adds into the accumulator, tracks errors, registers the result.
module bpsid_back
    import bpsid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       narrow_result,
    input  logic       q_valid,
    input  work_item_t q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    logic [ValueWidth-1:0] acc_reg, acc_next;
    logic [1:0]            err_reg, err_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic [ValueWidth-1:0] acc_base;
    logic [1:0]            err_base;
    logic [ValueWidth-1:0] shifted;
    logic [ValueWidth-1:0] sum;
    logic                  shift_ovf;
    logic                  add_ovf;
    logic                  out_of_range;
    logic [1:0]            status;

    assign q_pop   = q_valid && (!q_item.last || !m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        acc_base  = q_item.first ? '0 : acc_reg;
        err_base  = q_item.first ? STATUS_OK : err_reg;
        shifted   = {acc_base[ValueWidth-2:0], 1'b0};
        shift_ovf = shifted[ValueWidth-1] != acc_base[ValueWidth-1];
        sum       = shifted + q_item.addend;
        add_ovf   = (shifted[ValueWidth-1] == q_item.addend[ValueWidth-1]) &&
                    (sum[ValueWidth-1] != shifted[ValueWidth-1]);
        acc_next  = acc_base;
        err_next  = err_base;
        if (err_base == STATUS_OK) begin
            if (shift_ovf) begin
                err_next = STATUS_OVERFLOW;
            end else if (q_item.invalid) begin
                err_next = STATUS_INVALID;
            end else if (add_ovf) begin
                err_next = STATUS_OVERFLOW;
            end else begin
                acc_next = sum;
            end
        end
        out_of_range = !((&acc_next[ValueWidth-1:31]) || !(|acc_next[ValueWidth-1:31]));
        status = err_next;
        if (status == STATUS_OK && narrow_result && out_of_range) begin
            status = STATUS_RANGE;
        end
        m_data_next.status = status;
        m_data_next.value  = (status == STATUS_OK) ? $signed(acc_next) : '0;

        m_valid_next = m_valid_reg && !m_ready;
        if (q_pop && q_item.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            err_reg     <= STATUS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                acc_reg <= acc_next;
                err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.last) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== design/binary_poly_signed_int_decoder.sv =====
// Top level of the binary polynomial signed integer decoder.
// Usage:
//   s_valid/s_ready/s_data carry coefficients, highest degree first. s_data.first
//   starts a new polynomial, s_data.last marks the constant coefficient.
//   m_valid/m_ready/m_data carry one result per polynomial: the signed value
//   evaluated at two, and a status (ok, coefficient not below modulus,
//   overflow, outside int32). Errors are sticky inside a polynomial.
//   cfg_we/cfg_index/cfg_wdata write the plaintext modulus (0) and narrow_result (1);
//   write only while the block is idle.
// Timing:
//   One coefficient per cycle while s_ready is high. The front end classifies
//   each coefficient in the accept cycle into a QueueDepth-entry queue; the
//   accumulator consumes one entry per cycle unless a last item waits on a held
//   result. The accumulator's double-and-add loop sets the one-item-per-cycle rate.
// Reset and stall:
//   aresetn (synchronous) sets the modulus to 2, narrow_result to 0 and clears
//   accumulator, error and queue. While a result waits with m_ready low, the result
//   register holds; items keep flowing until a last item reaches the back end, and the
//   queue absorbs input until full.
module binary_poly_signed_int_decoder
    import bpsid_pkg::*;
#(
    parameter int QueueDepth = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CoeffWidth-1:0] cfg_wdata
);

    logic [CoeffWidth-1:0] modulus_reg;
    logic                  narrow_result_reg;
    work_item_t            front_item;
    work_item_t            q_item;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg       <= CoeffWidth'(2);
            narrow_result_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MODULUS:       modulus_reg       <= cfg_wdata;
                CFG_NARROW_RESULT: narrow_result_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;

    bpsid_front u_front (
        .modulus   (modulus_reg),
        .in_item   (s_data),
        .work_item (front_item)
    );

    bpsid_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    bpsid_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .narrow_result (narrow_result_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

// ===== sim/decode_checker.sv =====
// Checker for the binary polynomial signed integer decoder: predicts and compares results.
module decode_checker
    import bpsid_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CoeffWidth-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    logic [CoeffWidth-1:0] modulus;
    logic                  narrow;
    logic [ValueWidth-1:0] acc;
    logic [1:0]            err;
    out_item_t             decoded_q[$];
    int                    fail_cnt = 0;

    function automatic void fold_coeff(input logic [CoeffWidth-1:0] c);
        logic [63:0] p;
        logic [63:0] thr;
        logic [63:0] shifted;
        logic [63:0] mag;
        logic [63:0] addend;
        logic [63:0] sum;
        logic        neg;
        p = 64'(modulus);
        thr = (p == 64'd2) ? 64'd2 : ((p + 64'd1) >> 1);
        shifted = acc << 1;
        if (shifted[63] != acc[63]) begin
            err = STATUS_OVERFLOW;
            return;
        end
        if (64'(c) >= p) begin
            err = STATUS_INVALID;
            return;
        end
        neg = 64'(c) >= thr;
        mag = neg ? (p - 64'(c)) : 64'(c);
        addend = neg ? (64'd0 - mag) : mag;
        sum = shifted + addend;
        if (shifted[63] == neg && shifted[63] != sum[63]) begin
            err = STATUS_OVERFLOW;
            return;
        end
        acc = sum;
    endfunction

    function automatic out_item_t closing_result();
        out_item_t  r;
        logic [1:0] st;
        st = err;
        if (st == STATUS_OK && narrow && (acc + 64'h8000_0000) > 64'hFFFF_FFFF)
            st = STATUS_RANGE;
        r.value = (st == STATUS_OK) ? acc : '0;
        r.status = st;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            modulus = 60'd2;
            narrow = 1'b0;
            acc = '0;
            err = STATUS_OK;
            decoded_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: value %0d status %0d", m_data.value,
                           m_data.status);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_data.value);
                        fail_cnt++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.first) begin
                    acc = '0;
                    err = STATUS_OK;
                end
                if (err == STATUS_OK)
                    fold_coeff(s_data.coeff);
                if (s_data.last)
                    decoded_q.push_back(closing_result());
            end
            if (cfg_we) begin
                if (cfg_index == CFG_MODULUS)
                    modulus = cfg_wdata;
                else
                    narrow = cfg_wdata[0];
            end
        end
        mismatches <= fail_cnt;
        outstanding <= decoded_q.size();
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the binary polynomial signed integer decoder: stimulus and verdict.
module testbench;
    import bpsid_pkg::*;

    localparam logic [CoeffWidth-1:0] MaxCoeff = '1;
    localparam logic [CoeffWidth-1:0] PosMax   = 60'h7FF_FFFF_FFFF_FFFF;
    localparam logic [CoeffWidth-1:0] NegEdge  = 60'h800_0000_0000_0000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = CFG_MODULUS;
    logic [CoeffWidth-1:0] cfg_wdata = '0;

    int                    mismatches;
    int                    outstanding;
    int                    send_idle = 0;
    int                    recv_stall = 0;
    logic [CoeffWidth-1:0] cur_mod = 60'd2;

    binary_poly_signed_int_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    decode_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input logic [CoeffWidth-1:0] c, input logic f, input logic l);
        in_item_t item;
        item.coeff = c;
        item.first = f;
        item.last = l;
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off until every pending result is out and the pipeline has emptied
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CoeffWidth-1:0] data);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [CoeffWidth-1:0] p, input logic n);
        write_reg(CFG_MODULUS, p);
        write_reg(CFG_NARROW_RESULT, {59'd0, n});
        cur_mod = p;
    endtask

    function automatic logic [CoeffWidth-1:0] pick_coeff(input logic [CoeffWidth-1:0] p);
        logic [63:0] wide;
        logic [63:0] thr;
        int unsigned r;
        wide = {$urandom, $urandom};
        thr = (64'(p) + 64'd1) >> 1;
        r = $urandom_range(99);
        if (r < 25)
            return '0;
        if (r < 40)
            return 60'd1;
        if (p == 0)
            return wide[CoeffWidth-1:0];
        if (r < 50)
            return p - 60'd1;
        if (r < 58)
            return 60'(thr) - 60'($urandom_range(1));
        if (r < 85)
            return 60'(wide % 64'(p));
        if (r < 92)
            return wide[CoeffWidth-1:0];
        return p + 60'($urandom_range(3));
    endfunction

    function automatic logic [CoeffWidth-1:0] seg_modulus(input int seg);
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case (seg)
            0: return MaxCoeff;
            1: return 60'd3;
            2: return wide[CoeffWidth-1:0] | 60'h100_0000_0000;
            3: return 60'd2;
            4: return 60'h1_0000_0001;
            5: return 60'd1;
            6: return 60'(2 + $urandom_range(998));
            7: return 60'd0;
            8: return wide[CoeffWidth-1:0];
            default: return MaxCoeff;
        endcase
    endfunction

    initial begin
        int sent;
        int len;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings; the first items continue from the cleared state
        send_item(60'd1, 1'b0, 1'b1);
        send_item(60'd1, 1'b0, 1'b1);
        send_item(60'd2, 1'b1, 1'b1);
        send_item(60'd0, 1'b1, 1'b0);
        send_item(60'd0, 1'b0, 1'b0);
        send_item(60'd1, 1'b0, 1'b0);
        send_item(60'd0, 1'b0, 1'b0);
        send_item(60'd1, 1'b0, 1'b1);

        set_config(MaxCoeff, 1'b0);
        send_item(MaxCoeff, 1'b1, 1'b1);
        send_item(PosMax, 1'b1, 1'b0);
        send_item(60'd1, 1'b0, 1'b0);
        send_item(60'd1, 1'b0, 1'b0);
        send_item(60'd1, 1'b0, 1'b0);
        send_item(60'd2, 1'b0, 1'b1);
        send_item(NegEdge, 1'b1, 1'b0);
        send_item(MaxCoeff - 60'd2, 1'b0, 1'b0);
        send_item(60'd0, 1'b0, 1'b0);
        send_item(60'd0, 1'b0, 1'b0);
        send_item(60'd0, 1'b0, 1'b1);

        set_config(60'd0, 1'b1);
        send_item(60'd0, 1'b1, 1'b1);

        set_config(60'd1, 1'b1);
        send_item(60'd0, 1'b1, 1'b1);
        send_item(60'd1, 1'b1, 1'b0);
        send_item(60'd0, 1'b0, 1'b1);

        set_config(60'h1_0000_0001, 1'b1);
        send_item(60'h8000_0000, 1'b1, 1'b1);
        send_item(60'h8000_0001, 1'b1, 1'b1);
        send_item(60'h7FFF_FFFF, 1'b1, 1'b1);

        for (int seg = 0; seg < 10; seg++) begin
            set_config(seg_modulus(seg), seg % 3 == 1);
            case (seg % 4)
                0: begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle = 76;
                    recv_stall = 0;
                end
                2: begin
                    send_idle = 0;
                    recv_stall = 76;
                end
                default: begin
                    send_idle = 33;
                    recv_stall = 33;
                end
            endcase
            sent = 0;
            while (sent < 100) begin
                if ($urandom_range(99) < 85) begin
                    case ($urandom_range(19))
                        0: len = $urandom_range(70, 25);
                        1, 2, 3: len = $urandom_range(24, 9);
                        default: len = $urandom_range(8, 1);
                    endcase
                    for (int i = 0; i < len; i++)
                        send_item(pick_coeff(cur_mod), i == 0, i == len - 1);
                end else begin
                    len = $urandom_range(4, 1);
                    for (int i = 0; i < len; i++)
                        send_item(pick_coeff(cur_mod), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                end
                sent += len;
                if ($urandom_range(99) < 3)
                    wait_drained();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bpsid_pkg.sv
design/bpsid_front.sv
design/bpsid_queue.sv
design/bpsid_back.sv
design/binary_poly_signed_int_decoder.sv
sim/decode_checker.sv
sim/testbench.sv
